@@ rtl/scti_pkg.sv @@
`default_nettype none

package scti_pkg;

    // Default configuration of the table and the fixed-point formats
    localparam int TABLE_STEPS_DEF     = 360;
    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int OUT_FRAC_BITS_DEF   = 14;

    // Port widths set by the item format
    localparam int ANGLE_W = 16;
    localparam int VALUE_W = 16;

    // pi and pi/2 in Q30
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Function select codes
    localparam logic OP_SIN = 1'b0;
    localparam logic OP_COS = 1'b1;

    // Round a Q30 constant to the angle format, half up
    function automatic longint unsigned angle_fix(longint unsigned q30, int frac_bits);
        longint unsigned half;
        half = 64'd1 << (29 - frac_bits);
        return (q30 + half) >> (30 - frac_bits);
    endfunction

endpackage

`default_nettype wire

@@ rtl/scti_cdiv.sv @@
`default_nettype none

// Pipelined divide by a constant: reciprocal multiply, back-multiply,
// then one compare-and-subtract correction. Three register stages.
module scti_cdiv #(
    parameter int              NUM_W   = 23,
    parameter longint unsigned DIVISOR = 64'd12868,
    parameter int              Q_W     = 9,
    parameter int              R_W     = 14,
    parameter int              SIDE_W  = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              up_valid,
    output logic                   up_ready,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [SIDE_W-1:0] up_side,
    output logic                   dn_valid,
    input  wire logic              dn_ready,
    output logic [Q_W-1:0]         quo,
    output logic [R_W-1:0]         rem,
    output logic [SIDE_W-1:0]      dn_side
);

    localparam int              STAGES = 3;
    // floor(2^NUM_W / DIVISOR) never overestimates; the quotient is low by at most one
    localparam longint unsigned MULT   = (64'd1 << NUM_W) / DIVISOR;
    localparam int              MW     = $clog2(MULT + 1);
    localparam int              DW     = $clog2(DIVISOR + 1);
    localparam int              RW2    = DW + 1;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   adv;

    logic [MW-1:0]     qe1_next;
    logic [MW-1:0]     qe1_reg;
    logic [NUM_W-1:0]  n1_reg;
    logic [SIDE_W-1:0] side1_reg;

    logic [NUM_W-1:0]  p2_next;
    logic [NUM_W-1:0]  p2_reg;
    logic [MW-1:0]     qe2_reg;
    logic [NUM_W-1:0]  n2_reg;
    logic [SIDE_W-1:0] side2_reg;

    logic [NUM_W-1:0]  diff;
    logic [RW2-1:0]    rr;
    logic [Q_W-1:0]    quo_next;
    logic [R_W-1:0]    rem_next;
    logic [Q_W-1:0]    quo_reg;
    logic [R_W-1:0]    rem_reg;
    logic [SIDE_W-1:0] side3_reg;

    // A stage loads when it is empty or its contents move on
    always_comb
    begin
        adv[STAGES] = dn_ready;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign up_ready = adv[0];
    assign dn_valid = valid_reg[STAGES-1];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= up_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Estimate the quotient by the reciprocal
    always_comb
    begin
        qe1_next = MW'(((NUM_W + MW)'(num) * (NUM_W + MW)'(MULT)) >> NUM_W);
    end

    // Multiply the estimate back by the divisor
    always_comb
    begin
        p2_next = NUM_W'((MW + DW)'(qe1_reg) * (MW + DW)'(DIVISOR));
    end

    // Correct the estimate by one step
    always_comb
    begin
        diff = n2_reg - p2_reg;
        rr   = RW2'(diff);
        if (rr >= RW2'(DIVISOR))
        begin
            quo_next = Q_W'(qe2_reg + 1'b1);
            rem_next = R_W'(rr - RW2'(DIVISOR));
        end
        else
        begin
            quo_next = Q_W'(qe2_reg);
            rem_next = R_W'(rr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            qe1_reg   <= qe1_next;
            n1_reg    <= num;
            side1_reg <= up_side;
        end
        if (adv[1])
        begin
            p2_reg    <= p2_next;
            qe2_reg   <= qe1_reg;
            n2_reg    <= n1_reg;
            side2_reg <= side1_reg;
        end
        if (adv[2])
        begin
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
            side3_reg <= side2_reg;
        end
    end

    assign quo     = quo_reg;
    assign rem     = rem_reg;
    assign dn_side = side3_reg;

endmodule

`default_nettype wire

@@ rtl/scti_fold.sv @@
`default_nettype none

// Saturate, shift for cosine, fold into the first quadrant and scale to
// table steps. Three register stages.
module scti_fold import scti_pkg::*; #(
    parameter int TABLE_STEPS     = TABLE_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      up_valid,
    output logic                           up_ready,
    input  wire logic                      op,
    input  wire logic signed [ANGLE_W-1:0] angle,
    output logic                           dn_valid,
    input  wire logic                      dn_ready,
    output logic [$clog2(angle_fix(HALF_PI_Q30, ANGLE_FRAC_BITS) * TABLE_STEPS + 1)-1:0] n,
    output logic                           neg
);

    localparam int              STAGES = 3;
    localparam longint unsigned PA     = angle_fix(PI_Q30, ANGLE_FRAC_BITS);
    localparam longint unsigned HA     = angle_fix(HALF_PI_Q30, ANGLE_FRAC_BITS);
    localparam int AW = (ANGLE_FRAC_BITS + 4 > ANGLE_W) ? ANGLE_FRAC_BITS + 4 : ANGLE_W;
    localparam int HW = $clog2(HA + 1);
    localparam int SW = $clog2(TABLE_STEPS + 1);
    localparam int NW = $clog2(HA * TABLE_STEPS + 1);

    localparam logic signed [AW-1:0] PA_S     = AW'(PA);
    localparam logic signed [AW-1:0] HA_S     = AW'(HA);
    localparam logic signed [AW-1:0] TWO_PA_S = AW'(2 * PA);
    localparam logic        [SW-1:0] STEPS_C  = SW'(TABLE_STEPS);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   adv;

    logic signed [AW-1:0] a0;
    logic signed [AW-1:0] a1_next;
    logic signed [AW-1:0] a1_reg;

    logic signed [AW-1:0] m;
    logic [HW-1:0]        af_next;
    logic [HW-1:0]        af_reg;
    logic                 neg2_next;
    logic                 neg2_reg;

    logic [HW+SW-1:0]     n_full;
    logic [NW-1:0]        n_reg;
    logic                 neg3_reg;

    always_comb
    begin
        adv[STAGES] = dn_ready;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign up_ready = adv[0];
    assign dn_valid = valid_reg[STAGES-1];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= up_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Saturate to +/-pi, then add pi/2 for cosine and wrap by 2*pi
    always_comb
    begin
        a0 = AW'(angle);
        if (a0 > PA_S)
        begin
            a1_next = PA_S;
        end
        else if (a0 < -PA_S)
        begin
            a1_next = -PA_S;
        end
        else
        begin
            a1_next = a0;
        end
        if (op == OP_COS)
        begin
            a1_next = a1_next + HA_S;
            if (a1_next > PA_S)
            begin
                a1_next = a1_next - TWO_PA_S;
            end
        end
    end

    // Take the magnitude and mirror the second quadrant onto the first
    always_comb
    begin
        neg2_next = a1_reg < 0;
        m         = neg2_next ? -a1_reg : a1_reg;
        if (m > HA_S)
        begin
            m = PA_S - m;
        end
        af_next = HW'(m);
    end

    // Scale the folded angle to table steps
    always_comb
    begin
        n_full = (HW + SW)'(af_reg) * (HW + SW)'(STEPS_C);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            a1_reg <= a1_next;
        end
        if (adv[1])
        begin
            af_reg   <= af_next;
            neg2_reg <= neg2_next;
        end
        if (adv[2])
        begin
            n_reg    <= NW'(n_full);
            neg3_reg <= neg2_reg;
        end
    end

    assign n   = n_reg;
    assign neg = neg3_reg;

endmodule

`default_nettype wire

@@ rtl/scti_interp.sv @@
`default_nettype none

// Read the two neighboring sine samples and form the interpolation
// numerator. The table is split into even and odd samples so that both
// neighbors come from one read of each half. Two register stages.
module scti_interp import scti_pkg::*; #(
    parameter int TABLE_STEPS     = TABLE_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 up_valid,
    output logic                                      up_ready,
    input  wire logic [$clog2(TABLE_STEPS + 1)-1:0]   idx,
    input  wire logic [$clog2(angle_fix(HALF_PI_Q30, ANGLE_FRAC_BITS))-1:0] frac,
    input  wire logic                                 up_neg,
    output logic                                      dn_valid,
    input  wire logic                                 dn_ready,
    output logic [OUT_FRAC_BITS + $clog2(angle_fix(HALF_PI_Q30, ANGLE_FRAC_BITS)) + 1:0] num,
    output logic [OUT_FRAC_BITS:0]                    lo,
    output logic                                      dn_neg
);

    localparam int              STAGES = 2;
    localparam longint unsigned HA     = angle_fix(HALF_PI_Q30, ANGLE_FRAC_BITS);
    localparam int              KW     = $clog2(TABLE_STEPS + 1);
    localparam int              RHW    = $clog2(HA);
    localparam int              RW     = OUT_FRAC_BITS + 1;
    localparam int              TW     = RW + RHW + 1;
    localparam int              NE     = TABLE_STEPS / 2 + 2;
    localparam int              EAW    = $clog2(NE);

    localparam logic [KW-1:0]   LAST_K  = KW'(TABLE_STEPS);
    localparam logic [TW-1:0]   HALF_HA = TW'(HA / 2);

    // (2k)(2k+1) for the terms of the sine series
    localparam longint unsigned TAYLOR_DIV [1:10] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef logic [RW-1:0] tab_t [NE];

    // sin(x) in Q30 for 0 <= x <= pi/2, by the first eleven terms of the series
    function automatic longint unsigned sin_q30(longint unsigned x);
        longint unsigned term;
        longint          sum;
        int              k;
        term = x;
        sum  = $signed(x);
        for (k = 1; k <= 10; k++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[k];
            if (k[0])
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > (64'sd1 <<< 30))
        begin
            sum = 64'sd1 <<< 30;
        end
        return $unsigned(sum);
    endfunction

    // Sample i of the table; zero past the end
    function automatic longint unsigned rom_entry(int i);
        longint unsigned x;
        longint unsigned s;
        if (i == 0 || i > TABLE_STEPS)
        begin
            return 64'd0;
        end
        if (i == TABLE_STEPS)
        begin
            return 64'd1 << OUT_FRAC_BITS;
        end
        x = (longint'(i) * HALF_PI_Q30 + TABLE_STEPS / 2) / TABLE_STEPS;
        s = sin_q30(x);
        if (OUT_FRAC_BITS < 30)
        begin
            s = (s + (64'd1 << (29 - (OUT_FRAC_BITS < 30 ? OUT_FRAC_BITS : 29))))
                >> (30 - (OUT_FRAC_BITS < 30 ? OUT_FRAC_BITS : 29));
        end
        return s;
    endfunction

    function automatic tab_t build_tab(int first);
        tab_t t;
        for (int j = 0; j < NE; j++)
        begin
            t[j] = RW'(rom_entry(2 * j + first));
        end
        return t;
    endfunction

    localparam tab_t EVEN_TAB = build_tab(0);
    localparam tab_t ODD_TAB  = build_tab(1);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   adv;

    logic [EAW-1:0] addr_e;
    logic [EAW-1:0] addr_o;
    logic [RW-1:0]  ev;
    logic [RW-1:0]  od;
    logic [RW-1:0]  lo_next;
    logic [RW-1:0]  hi;
    logic [RW-1:0]  diff_next;

    logic [RW-1:0]  lo1_reg;
    logic [RW-1:0]  diff1_reg;
    logic [RHW-1:0] frac1_reg;
    logic           neg1_reg;

    logic [TW-1:0]  num_next;
    logic [TW-1:0]  num_reg;
    logic [RW-1:0]  lo2_reg;
    logic           neg2_reg;

    always_comb
    begin
        adv[STAGES] = dn_ready;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign up_ready = adv[0];
    assign dn_valid = valid_reg[STAGES-1];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= up_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Look up samples k and k+1; drop the slope at the table end or if it falls
    always_comb
    begin
        addr_o = EAW'(idx >> 1);
        addr_e = EAW'(idx >> 1) + EAW'(idx[0]);
        ev     = EVEN_TAB[addr_e];
        od     = ODD_TAB[addr_o];
        lo_next = idx[0] ? od : ev;
        hi      = idx[0] ? ev : od;
        if (idx < LAST_K && hi >= lo_next)
        begin
            diff_next = hi - lo_next;
        end
        else
        begin
            diff_next = '0;
        end
    end

    // Weight the slope by the remainder and add half a step for rounding
    always_comb
    begin
        num_next = TW'((RW + RHW)'(diff1_reg) * (RW + RHW)'(frac1_reg)) + HALF_HA;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            lo1_reg   <= lo_next;
            diff1_reg <= diff_next;
            frac1_reg <= frac;
            neg1_reg  <= up_neg;
        end
        if (adv[1])
        begin
            num_reg  <= num_next;
            lo2_reg  <= lo1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    assign num    = num_reg;
    assign lo     = lo2_reg;
    assign dn_neg = neg2_reg;

endmodule

`default_nettype wire

@@ rtl/sine_cosine_table_interp_unit.sv @@
// Sine and cosine of a signed Q2.13 angle in radians (op 0 sine, op 1
// cosine), returned as signed Q1.14 by a quarter-wave table of
// TABLE_STEPS+1 samples with linear interpolation; angles beyond +/-pi
// saturate. The unit is a 12-stage pipeline: 3 stages fold the angle and
// scale it to table steps, 3 divide by the constant pi/2 to get the table
// index and remainder, 2 read the table and weight the slope, 3 divide by
// pi/2 again for the interpolated step, and 1 forms the signed result.
// A new angle is taken every cycle unless an output stall has backed up
// to the first stage. Stalls back up stage by stage, so empty stages keep
// filling while a result waits. Results leave in the order the angles
// came in.
`default_nettype none

module sine_cosine_table_interp_unit import scti_pkg::*; #(
    parameter int TABLE_STEPS     = TABLE_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_ready,
    input  wire logic                      op,
    input  wire logic signed [ANGLE_W-1:0] angle,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    output logic signed [VALUE_W-1:0]      value
);

    localparam longint unsigned HA  = angle_fix(HALF_PI_Q30, ANGLE_FRAC_BITS);
    localparam int              NW  = $clog2(HA * TABLE_STEPS + 1);
    localparam int              KW  = $clog2(TABLE_STEPS + 1);
    localparam int              RHW = $clog2(HA);
    localparam int              RW  = OUT_FRAC_BITS + 1;
    localparam int              TW  = RW + RHW + 1;
    localparam int              VW  = (RW > VALUE_W) ? RW : VALUE_W;

    logic          fold_valid;
    logic          fold_ready;
    logic [NW-1:0] fold_n;
    logic          fold_neg;

    logic           idx_valid;
    logic           idx_ready;
    logic [KW-1:0]  idx_q;
    logic [RHW-1:0] idx_r;
    logic           idx_neg;

    logic          ip_valid;
    logic          ip_ready;
    logic [TW-1:0] ip_num;
    logic [RW-1:0] ip_lo;
    logic          ip_neg;

    logic          step_valid;
    logic          step_ready;
    logic [RW-1:0] step_q;
    logic [RW:0]   step_side;

    logic [VW-1:0]      sum;
    logic [VW-1:0]      res;
    logic [VALUE_W-1:0] value_next;
    logic [VALUE_W-1:0] value_reg;
    logic               rsp_valid_reg;
    logic               out_adv;

    scti_fold #(
        .TABLE_STEPS     (TABLE_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_fold (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req_valid),
        .up_ready (req_ready),
        .op       (op),
        .angle    (angle),
        .dn_valid (fold_valid),
        .dn_ready (fold_ready),
        .n        (fold_n),
        .neg      (fold_neg)
    );

    // Table index and remainder: n / (pi/2)
    scti_cdiv #(
        .NUM_W   (NW),
        .DIVISOR (HA),
        .Q_W     (KW),
        .R_W     (RHW),
        .SIDE_W  (1)
    ) u_idx_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (fold_valid),
        .up_ready (fold_ready),
        .num      (fold_n),
        .up_side  (fold_neg),
        .dn_valid (idx_valid),
        .dn_ready (idx_ready),
        .quo      (idx_q),
        .rem      (idx_r),
        .dn_side  (idx_neg)
    );

    scti_interp #(
        .TABLE_STEPS     (TABLE_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .OUT_FRAC_BITS   (OUT_FRAC_BITS)
    ) u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (idx_valid),
        .up_ready (idx_ready),
        .idx      (idx_q),
        .frac     (idx_r),
        .up_neg   (idx_neg),
        .dn_valid (ip_valid),
        .dn_ready (ip_ready),
        .num      (ip_num),
        .lo       (ip_lo),
        .dn_neg   (ip_neg)
    );

    // Interpolated step: rounded (slope * remainder) / (pi/2)
    scti_cdiv #(
        .NUM_W   (TW),
        .DIVISOR (HA),
        .Q_W     (RW),
        .R_W     (RHW),
        .SIDE_W  (RW + 1)
    ) u_step_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (ip_valid),
        .up_ready (ip_ready),
        .num      (ip_num),
        .up_side  ({ip_neg, ip_lo}),
        .dn_valid (step_valid),
        .dn_ready (step_ready),
        .quo      (step_q),
        .rem      (),
        .dn_side  (step_side)
    );

    // Output register loads when empty or when its result is taken
    assign out_adv    = !rsp_valid_reg || rsp_ready;
    assign step_ready = out_adv;

    // Add the step to the lower sample and restore the sign
    always_comb
    begin
        sum        = VW'(step_side[RW-1:0]) + VW'(step_q);
        res        = step_side[RW] ? -sum : sum;
        value_next = res[VALUE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            rsp_valid_reg <= step_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            value_reg <= value_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign value     = value_reg;

endmodule

`default_nettype wire
